FILE: rtl/fbwd_pkg.sv
package fbwd_pkg;

    // Window shape and channel count
    localparam int SAMPLES_PER_WINDOW = 4;
    localparam int NUM_BUMPERS        = 4;

    // Fixed field widths
    localparam int LEVEL_W    = 4;
    localparam int INTERVAL_W = 8;
    localparam int TICK_W     = 8;

    // Derived widths
    localparam int WIN_W   = SAMPLES_PER_WINDOW + 1;
    localparam int CNT_W   = $clog2(SAMPLES_PER_WINDOW + 1);
    localparam int IDX_W   = $clog2(SAMPLES_PER_WINDOW);
    localparam int BUMP_W  = (NUM_BUMPERS > LEVEL_W) ? NUM_BUMPERS : LEVEL_W;

    // Window patterns
    localparam logic [WIN_W-1:0] PRESS_PAT = WIN_W'((1 << SAMPLES_PER_WINDOW) - 1);
    localparam logic [WIN_W-1:0] FLAG_PAT  = WIN_W'(1 << SAMPLES_PER_WINDOW);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(SAMPLES_PER_WINDOW);

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_IDX_INTERVAL = 1'b0;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(10);

    typedef logic [WIN_W-1:0] t_window;

    // One result beat
    typedef struct packed {
        logic               changed;
        logic               pressed;
        logic [LEVEL_W-1:0] bumper_onehot;
    } t_result;

endpackage

FILE: rtl/fbwd_in_if.sv
interface fbwd_in_if import fbwd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] bumper_levels;

    modport source (output valid, output bumper_levels, input ready);
    modport sink   (input valid, input bumper_levels, output ready);
endinterface

FILE: rtl/fbwd_out_if.sv
interface fbwd_out_if import fbwd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               changed;
    logic               pressed;
    logic [LEVEL_W-1:0] bumper_onehot;

    modport source (output valid, output changed, output pressed, output bumper_onehot,
                    input ready);
    modport sink   (input valid, input changed, input pressed, input bumper_onehot,
                    output ready);
endinterface

FILE: rtl/fbwd_core.sv
module fbwd_core import fbwd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [LEVEL_W-1:0]    i_levels,
    input  logic [INTERVAL_W-1:0] i_interval,
    output t_result               o_result
);

    logic [TICK_W-1:0] r_tick;
    logic [TICK_W-1:0] n_tick;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    t_window           r_win [NUM_BUMPERS];
    t_window           n_win [NUM_BUMPERS];
    logic              moment;
    logic [TICK_W-1:0] tick_inc;
    logic [BUMP_W-1:0] levels_pad;

    // Prescaler: a moment when the advanced count reaches the interval
    assign tick_inc   = r_tick + TICK_W'(1);
    assign moment     = !(tick_inc < TICK_W'(i_interval));
    assign levels_pad = BUMP_W'(i_levels);

    // Next state and result for one tick
    always_comb begin
        logic              done;
        logic              prs;
        logic [BUMP_W-1:0] hit;
        done     = 1'b0;
        prs      = 1'b0;
        hit      = '0;
        n_tick   = moment ? '0 : tick_inc;
        n_count  = r_count;
        for (int ch = 0; ch < NUM_BUMPERS; ch++) begin
            n_win[ch] = r_win[ch];
        end
        if (moment) begin
            if (r_count == CNT_FULL) begin
                // Judge the window in priority order, stop at the first event
                n_count = '0;
                for (int ch = 0; ch < NUM_BUMPERS; ch++) begin
                    if (!done) begin
                        if (r_win[ch] == PRESS_PAT) begin
                            n_win[ch] = FLAG_PAT;
                            hit[ch]   = 1'b1;
                            prs       = 1'b1;
                            done      = 1'b1;
                        end else if (r_win[ch] == FLAG_PAT) begin
                            n_win[ch] = '0;
                            hit[ch]   = 1'b1;
                            done      = 1'b1;
                        end else begin
                            n_win[ch] = r_win[ch] & FLAG_PAT;
                        end
                    end
                end
            end else begin
                // OR each level into its sample slot
                n_count = r_count + CNT_W'(1);
                for (int ch = 0; ch < NUM_BUMPERS; ch++) begin
                    n_win[ch][r_count[IDX_W-1:0]] =
                        r_win[ch][r_count[IDX_W-1:0]] | levels_pad[ch];
                end
            end
        end
        o_result.changed       = done;
        o_result.pressed       = prs;
        o_result.bumper_onehot = hit[LEVEL_W-1:0];
    end

    // Advance state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_count <= '0;
            for (int ch = 0; ch < NUM_BUMPERS; ch++) begin
                r_win[ch] <= '0;
            end
        end else if (i_step) begin
            r_tick  <= n_tick;
            r_count <= n_count;
            for (int ch = 0; ch < NUM_BUMPERS; ch++) begin
                r_win[ch] <= n_win[ch];
            end
        end
    end

endmodule

FILE: rtl/four_bumper_window_debouncer_top.sv
// Window debouncer for four bumper switches.
// in_ch carries one beat per tick with the four raw bumper levels
// (bit 0 front-left .. bit 3 rear-right). out_ch returns exactly one beat
// for every input beat: changed, pressed and the one-hot bumper that changed.
// The APB port holds sample_interval at address 0 (reset value 10); write it
// only while no beat is in flight.
// The result of a beat appears on out_ch in the cycle after the beat is
// accepted. Throughput: one beat per cycle while the receiver takes each
// result, set by the single result register after the tick update.
// When the receiver stalls, the result register holds its beat and in_ch
// still takes a beat in any cycle where that beat is being taken; otherwise
// ready drops until the result is taken.
// Reset (synchronous, active low) clears the prescaler, the sample count,
// every channel window and the output valid, and reloads sample_interval.
module four_bumper_window_debouncer_top import fbwd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fbwd_in_if.sink               in_ch,
    fbwd_out_if.source            out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [INTERVAL_W-1:0] r_interval;
    logic                  r_out_valid;
    t_result               r_out;
    t_result               core_result;
    logic                  step;
    logic                  reg_idx;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign prdata  = (reg_idx == REG_IDX_INTERVAL) ? APB_DATA_W'(r_interval) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
        end else if (psel && penable && pwrite && pready
                     && (reg_idx == REG_IDX_INTERVAL)) begin
            r_interval <= pwdata[INTERVAL_W-1:0];
        end
    end

    // Take a beat whenever the result register is free or being drained
    assign in_ch.ready = !r_out_valid || out_ch.ready;
    assign step        = in_ch.valid && in_ch.ready;

    fbwd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_levels   (in_ch.bumper_levels),
        .i_interval (r_interval),
        .o_result   (core_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_result;
        end
    end

    assign out_ch.valid         = r_out_valid;
    assign out_ch.changed       = r_out.changed;
    assign out_ch.pressed       = r_out.pressed;
    assign out_ch.bumper_onehot = r_out.bumper_onehot;

endmodule

FILE: test/four_bumper_window_debouncer_top_tb.sv
module four_bumper_window_debouncer_top_tb import fbwd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;

    // Predicts each tick's event and holds the events still owed by the block
    class bumper_event_scoreboard;
        t_window                windows [NUM_BUMPERS];
        logic [CNT_W-1:0]       samples_taken;
        logic [TICK_W-1:0]      ticks;
        logic [INTERVAL_W-1:0]  interval;
        t_result                expected_events [$];
        int                     mismatches;

        function new();
            foreach (windows[ch]) windows[ch] = '0;
            samples_taken = '0;
            ticks         = '0;
            interval      = INTERVAL_RESET;
            mismatches    = 0;
        endfunction

        task report_mismatch(input string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        function int pending();
            return expected_events.size();
        endfunction

        // Advance the prescaler and the windows by one accepted tick
        function void note_tick(input logic [LEVEL_W-1:0] levels);
            t_result ev;
            bit      judged;
            ev     = '0;
            judged = 1'b0;
            ticks  = ticks + 1'b1;
            if (ticks >= interval) begin
                ticks = '0;
                if (samples_taken >= CNT_FULL) begin
                    // Judge the window, first event wins
                    samples_taken = '0;
                    for (int ch = 0; ch < NUM_BUMPERS; ch++) begin
                        if (!judged) begin
                            if (windows[ch] == PRESS_PAT) begin
                                windows[ch] = FLAG_PAT;
                                ev.changed  = 1'b1;
                                ev.pressed  = 1'b1;
                                if (ch < LEVEL_W) ev.bumper_onehot[ch] = 1'b1;
                                judged = 1'b1;
                            end else if (windows[ch] == FLAG_PAT) begin
                                windows[ch] = '0;
                                ev.changed  = 1'b1;
                                ev.pressed  = 1'b0;
                                if (ch < LEVEL_W) ev.bumper_onehot[ch] = 1'b1;
                                judged = 1'b1;
                            end else begin
                                windows[ch] = windows[ch] & FLAG_PAT;
                            end
                        end
                    end
                end else begin
                    // OR each level into its sample slot
                    for (int ch = 0; ch < NUM_BUMPERS; ch++) begin
                        if (ch < LEVEL_W && levels[ch])
                            windows[ch][samples_taken] = 1'b1;
                    end
                    samples_taken = samples_taken + 1'b1;
                end
            end
            expected_events.push_back(ev);
        endfunction

        // Compare one result beat with the oldest expected event
        task check_event(input t_result got);
            t_result want;
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result %b/%b/%b",
                                          got.changed, got.pressed, got.bumper_onehot));
                return;
            end
            want = expected_events.pop_front();
            if (got.changed !== want.changed)
                report_mismatch($sformatf("changed %b, want %b", got.changed, want.changed));
            if (got.pressed !== want.pressed)
                report_mismatch($sformatf("pressed %b, want %b", got.pressed, want.pressed));
            if (got.bumper_onehot !== want.bumper_onehot)
                report_mismatch($sformatf("bumper_onehot %b, want %b",
                                          got.bumper_onehot, want.bumper_onehot));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    fbwd_in_if  in_if ();
    fbwd_out_if out_if ();

    bumper_event_scoreboard sb;
    bit                     idle_en;
    int                     cycles;
    logic [LEVEL_W-1:0]     held_levels;

    four_bumper_window_debouncer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Drive every input to a known value before the first edge
    initial begin
        sb                  = new();
        i_rst_n             = 1'b0;
        idle_en             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.bumper_levels = '0;
        out_if.ready        = 1'b1;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        held_levels         = '0;
        cycles              = 0;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        if (idle_en)
            out_if.ready <= ($urandom_range(0, 99) >= 6);
        else
            out_if.ready <= 1'b1;
    end

    // Watch both channels: check results first, then note new ticks
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got.changed       = out_if.changed;
                got.pressed       = out_if.pressed;
                got.bumper_onehot = out_if.bumper_onehot;
                sb.check_event(got);
            end
            if (in_if.valid && in_if.ready)
                sb.note_tick(in_if.bumper_levels);
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one tick beat and hold it until taken
    task automatic send_levels(input logic [LEVEL_W-1:0] levels);
        if (idle_en) begin
            while ($urandom_range(0, 99) < 6) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_if.valid         <= 1'b1;
        in_if.bumper_levels <= levels;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Drop valid and hold until every expected event has come back
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == '0) sb.interval = data[INTERVAL_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic apb_check_interval();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(sb.interval))
            sb.report_mismatch($sformatf("sample_interval read %0h, want %0h",
                                         prdata, sb.interval));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly steady levels that flip now and then, with bounce and some junk
    function automatic logic [LEVEL_W-1:0] next_levels();
        logic [LEVEL_W-1:0] bounce;
        bounce = '0;
        for (int b = 0; b < LEVEL_W; b++) begin
            if ($urandom_range(0, 39) == 0) held_levels[b] = ~held_levels[b];
            if ($urandom_range(0, 24) == 0) bounce[b] = 1'b1;
        end
        if ($urandom_range(0, 99) < 3) return LEVEL_W'($urandom);
        return held_levels ^ bounce;
    endfunction

    task automatic run_random(input int n);
        repeat (n) send_levels(next_levels());
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset value, then a sample moment on every tick
        apb_check_interval();
        apb_write(3'd0, 32'd1);
        apb_check_interval();

        // Full presses in priority order, then releases, then mixed levels
        repeat (10) send_levels(4'hF);
        repeat (10) send_levels(4'h0);
        repeat (2) begin
            send_levels(4'h5);
            send_levels(4'hA);
        end
        send_levels(4'h5);
        drain();

        // Default interval
        apb_write(3'd0, 32'd10);
        idle_en <= 1'b1;
        run_random(100);
        drain();

        // Every tick a sample moment; open with a stretch without idling
        idle_en <= 1'b0;
        apb_write(3'd0, {8'($urandom_range(0, 255)), 24'h0} | 32'd1);
        apb_check_interval();
        run_random(200);
        idle_en <= 1'b1;
        run_random(250);
        drain();

        // Slowest prescaler
        apb_write(3'd0, {24'($urandom), 8'd0} | 32'd255);
        apb_check_interval();
        run_random(280);
        drain();

        // Lower the interval under the running tick count
        apb_write(3'd0, 32'd3);
        run_random(220);
        drain();

        // Zero interval behaves as one
        apb_write(3'd0, {24'($urandom), 8'd0});
        apb_check_interval();
        run_random(150);
        drain();

        // Write to an unmapped register: nothing changes
        apb_write(3'd4, $urandom);
        apb_check_interval();
        run_random(100);
        drain();

        // Pause the sender mid-phase until the block has caught up
        apb_write(3'd0, 32'd2);
        run_random(100);
        drain();
        run_random(100);
        drain();

        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
